[design/ccbt_pkg.sv]
// Package: shared types and constants for the closed cubic B-spline tessellator.
package ccbt_pkg;
	localparam int CW = 16;
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] RESET_STEPS = 5'd8;

	typedef struct packed {
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic signed [CW-1:0] point_z;
		logic final_point;
	} in_t;

	typedef struct packed {
		logic signed [CW-1:0] curve_x;
		logic signed [CW-1:0] curve_y;
		logic signed [CW-1:0] curve_z;
		logic run_end;
		logic too_few_points;
	} out_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} pt_t;

	// one segment job: four control points, last-of-run flag, error flag
	typedef struct packed {
		pt_t a;
		pt_t b;
		pt_t c;
		pt_t d;
		logic last;
		logic err;
	} job_t;

	// four Q1.16 basis weights, element k weights control point k
	typedef logic [3:0][16:0] w4_t;
endpackage

[design/closed_cubic_bspline_tessellator.sv]
// Closed cubic B-spline tessellator top level: front end, job queue, evaluator.
// Each segment job yields S curve points (an error job one), one per cycle unless out_ready stalls.
// Path: a segment's job passes the queue, the s2 register and the output register in order.
// A final request that closes a curve holds off the input while its three wrap jobs issue.
// New requests also wait while the job queue is full.
// Reset: arst_n clears history, queue, pipeline and sets steps_q to 8.
module closed_cubic_bspline_tessellator import ccbt_pkg::*; #(
	parameter int MAX_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data,
	input  logic cfg_we,
	input  logic [STEP_W-1:0] cfg_data
);
	logic [STEP_W-1:0] steps_q;
	logic fj_valid, fj_ready, qj_valid, qj_ready;
	job_t fj_data, qj_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			steps_q <= RESET_STEPS;
		else if (cfg_we)
			steps_q <= cfg_data;
	end

	ccbt_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data)
	);

	ccbt_queue #(.DEPTH(2)) u_queue (
		.clk, .arst_n,
		.wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj_data),
		.rd_valid(qj_valid), .rd_ready(qj_ready), .rd_data(qj_data)
	);

	ccbt_eval #(.MAX_STEPS(MAX_STEPS)) u_eval (
		.clk, .arst_n, .steps(steps_q),
		.job_valid(qj_valid), .job_ready(qj_ready), .job_data(qj_data),
		.out_valid, .out_ready, .out_data
	);
endmodule

[design/ccbt_front.sv]
// Front end: keeps point history and issues segment jobs into the queue.
module ccbt_front import ccbt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic job_valid,
	input  logic job_ready,
	output job_t job_data
);
	pt_t r_q [3];
	pt_t o_q [3];
	logic [2:0] seen_q;
	logic busy_q;
	logic [1:0] wrap_q;
	pt_t p;

	assign p = '{x: in_data.point_x, y: in_data.point_y, z: in_data.point_z};
	assign in_ready = !busy_q && job_ready;

	always_comb begin
		job_valid = 1'b0;
		job_data = '0;
		if (busy_q) begin
			job_valid = 1'b1;
			case (wrap_q)
				2'd0: job_data = '{a: r_q[0], b: r_q[1], c: r_q[2], d: o_q[0],
					last: 1'b0, err: 1'b0};
				2'd1: job_data = '{a: r_q[1], b: r_q[2], c: o_q[0], d: o_q[1],
					last: 1'b0, err: 1'b0};
				default: job_data = '{a: r_q[2], b: o_q[0], c: o_q[1], d: o_q[2],
					last: 1'b1, err: 1'b0};
			endcase
		end else if (in_valid) begin
			if (in_data.final_point && seen_q < 3'd3) begin
				job_valid = 1'b1;
				job_data = '0;
				job_data.last = 1'b1;
				job_data.err = 1'b1;
			end else if (seen_q >= 3'd3) begin
				job_valid = 1'b1;
				job_data = '{a: r_q[0], b: r_q[1], c: r_q[2], d: p,
					last: !in_data.final_point, err: 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			busy_q <= 1'b0;
			wrap_q <= '0;
			r_q <= '{default: '0};
			o_q <= '{default: '0};
		end else if (busy_q) begin
			if (job_ready) begin
				if (wrap_q == 2'd2) begin
					busy_q <= 1'b0;
					wrap_q <= '0;
					seen_q <= '0;
					r_q <= '{default: '0};
					o_q <= '{default: '0};
				end else begin
					wrap_q <= wrap_q + 2'd1;
				end
			end
		end else if (in_valid && in_ready) begin
			if (in_data.final_point && seen_q < 3'd3) begin
				seen_q <= '0;
				r_q <= '{default: '0};
				o_q <= '{default: '0};
			end else begin
				if (seen_q < 3'd3)
					o_q[seen_q[1:0]] <= p;
				r_q[0] <= r_q[1];
				r_q[1] <= r_q[2];
				r_q[2] <= p;
				seen_q <= (seen_q >= 3'd4) ? 3'd4 : seen_q + 3'd1;
				if (in_data.final_point)
					busy_q <= 1'b1;
			end
		end
	end
endmodule

[design/ccbt_queue.sv]
// Short job queue between front end and evaluator.
module ccbt_queue import ccbt_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	job_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

[design/ccbt_eval.sv]
// Evaluator: walks u over one segment, weights and sums the four points.
module ccbt_eval import ccbt_pkg::*; #(
	parameter int MAX_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [STEP_W-1:0] steps,
	input  logic job_valid,
	output logic job_ready,
	input  job_t job_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);
	localparam int SW = STEP_W;
	localparam int AW = 17 + CW + 2 + 1;
	localparam int IW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

	logic [SW-1:0] s_eff, i_q;
	logic [IW-1:0] s_idx, u_idx;
	logic run_s1;
	logic s2_valid, s2_stall;
	logic [16:0] wt [4];
	logic signed [AW-1:0] ax, ay, az;
	logic signed [AW-1:0] accx_s2, accy_s2, accz_s2;
	logic last_s2, err_s2;
	logic step_last;
	logic out_free;
	w4_t wtab [MAX_STEPS][MAX_STEPS];

	always_comb begin
		if (steps == '0)
			s_eff = SW'(1);
		else if (steps > SW'(MAX_STEPS))
			s_eff = SW'(MAX_STEPS);
		else
			s_eff = steps;
	end

	// weight table: (n*65536 + den/2) / den, den = 6 s^3
	for (genvar gs = 0; gs < MAX_STEPS; gs++) begin : g_s
		for (genvar gi = 0; gi < MAX_STEPS; gi++) begin : g_i
			localparam longint NS = longint'(gs + 1);
			localparam longint NI = longint'(gi);
			localparam longint NJ = NS - NI;
			localparam longint DEN = 6 * NS * NS * NS;
			localparam longint N0 = NJ * NJ * NJ;
			localparam longint N1 = 3 * NI * NI * NI - 6 * NI * NI * NS + 4 * NS * NS * NS;
			localparam longint N2 = -3 * NI * NI * NI + 3 * NI * NI * NS + 3 * NI * NS * NS
				+ NS * NS * NS;
			localparam longint N3 = NI * NI * NI;
			localparam logic [16:0] W0 = 17'((N0 * 65536 + DEN / 2) / DEN);
			localparam logic [16:0] W1 = 17'((N1 * 65536 + DEN / 2) / DEN);
			localparam logic [16:0] W2 = 17'((N2 * 65536 + DEN / 2) / DEN);
			localparam logic [16:0] W3 = 17'((N3 * 65536 + DEN / 2) / DEN);
			assign wtab[gs][gi] = {W3, W2, W1, W0};
		end
	end

	assign s_idx = IW'(s_eff - SW'(1));
	assign u_idx = IW'(i_q);

	always_comb begin
		for (int k = 0; k < 4; k++)
			wt[k] = wtab[s_idx][u_idx][k];
	end

	function automatic logic signed [AW-1:0] mac(input logic [16:0] w0, input logic [16:0] w1,
		input logic [16:0] w2, input logic [16:0] w3, input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b, input logic signed [CW-1:0] c,
		input logic signed [CW-1:0] d);
		return AW'($signed({1'b0, w0}) * a) + AW'($signed({1'b0, w1}) * b)
			+ AW'($signed({1'b0, w2}) * c) + AW'($signed({1'b0, w3}) * d);
	endfunction

	function automatic logic signed [CW-1:0] fin(input logic signed [AW-1:0] acc);
		logic signed [AW-1:0] r;
		logic signed [AW-17:0] q;
		r = acc + AW'(32768);
		q = r[AW-1:16];
		if (q > (AW-16)'((1 << (CW - 1)) - 1))
			return {1'b0, {(CW-1){1'b1}}};
		if (q < -(AW-16)'(1 << (CW - 1)))
			return {1'b1, {(CW-1){1'b0}}};
		return q[CW-1:0];
	endfunction

	assign ax = mac(wt[0], wt[1], wt[2], wt[3],
		job_data.a.x, job_data.b.x, job_data.c.x, job_data.d.x);
	assign ay = mac(wt[0], wt[1], wt[2], wt[3],
		job_data.a.y, job_data.b.y, job_data.c.y, job_data.d.y);
	assign az = mac(wt[0], wt[1], wt[2], wt[3],
		job_data.a.z, job_data.b.z, job_data.c.z, job_data.d.z);

	assign step_last = job_data.err || (i_q == s_eff - SW'(1));
	assign s2_stall = s2_valid && out_valid && !out_ready;
	assign run_s1 = job_valid && !s2_stall;
	assign job_ready = run_s1 && step_last;
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			s2_valid <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (run_s1)
				i_q <= step_last ? '0 : i_q + SW'(1);
			if (!s2_stall)
				s2_valid <= run_s1;
			if (out_free)
				out_valid <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (run_s1) begin
			accx_s2 <= job_data.err ? '0 : ax;
			accy_s2 <= job_data.err ? '0 : ay;
			accz_s2 <= job_data.err ? '0 : az;
			last_s2 <= job_data.last && step_last;
			err_s2 <= job_data.err;
		end
		if (out_free && s2_valid) begin
			out_data.curve_x <= err_s2 ? '0 : fin(accx_s2);
			out_data.curve_y <= err_s2 ? '0 : fin(accy_s2);
			out_data.curve_z <= err_s2 ? '0 : fin(accz_s2);
			out_data.run_end <= last_s2;
			out_data.too_few_points <= err_s2;
		end
	end
endmodule

[bench/tb_closed_cubic_bspline_tessellator.sv]
// Testbench: closed cubic B-spline tessellator checked against an in-bench curve predictor.
module tb_closed_cubic_bspline_tessellator;
	import ccbt_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic [STEP_W-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit recv_hold = 1'b0;
	int errors = 0;
	int quiet_cycles = 0;

	out_t curve_queue[$];
	pt_t recent_pts[3];
	pt_t opening_pts[3];
	int pts_seen = 0;
	logic [STEP_W-1:0] steps_reg = RESET_STEPS;

	closed_cubic_bspline_tessellator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint weight_q16(longint n, longint s);
		longint den;
		den = 6 * s * s * s;
		return (n * 65536 + den / 2) / den;
	endfunction

	function automatic logic signed [CW-1:0] blend_coord(longint w[4], longint c[4]);
		longint acc, r, q;
		acc = w[0] * c[0] + w[1] * c[1] + w[2] * c[2] + w[3] * c[3];
		r = acc + 32768;
		if (r >= 0) q = r / 65536;
		else q = -((-r + 65535) / 65536);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[CW-1:0];
	endfunction

	function automatic void add_expected(out_t r);
		curve_queue = {curve_queue, r};
	endfunction

	task automatic push_segment(pt_t a, pt_t b, pt_t c, pt_t d);
		longint s, i, j;
		longint w[4];
		longint cx[4], cy[4], cz[4];
		out_t r;
		s = steps_reg;
		if (s < 1) s = 1;
		if (s > 16) s = 16;
		cx = '{a.x, b.x, c.x, d.x};
		cy = '{a.y, b.y, c.y, d.y};
		cz = '{a.z, b.z, c.z, d.z};
		for (i = 0; i < s; i++) begin
			j = s - i;
			w[0] = weight_q16(j * j * j, s);
			w[1] = weight_q16(3 * i * i * i - 6 * i * i * s + 4 * s * s * s, s);
			w[2] = weight_q16(-3 * i * i * i + 3 * i * i * s + 3 * i * s * s + s * s * s, s);
			w[3] = weight_q16(i * i * i, s);
			r.curve_x = blend_coord(w, cx);
			r.curve_y = blend_coord(w, cy);
			r.curve_z = blend_coord(w, cz);
			r.run_end = 1'b0;
			r.too_few_points = 1'b0;
			add_expected(r);
		end
	endtask

	task automatic predict_curve(in_t req);
		pt_t p;
		out_t r;
		int n;
		n = pts_seen;
		p.x = req.point_x;
		p.y = req.point_y;
		p.z = req.point_z;
		if (n >= 3) push_segment(recent_pts[0], recent_pts[1], recent_pts[2], p);
		else opening_pts[n] = p;
		recent_pts[0] = recent_pts[1];
		recent_pts[1] = recent_pts[2];
		recent_pts[2] = p;
		pts_seen = (n >= 4) ? 4 : n + 1;
		if (req.final_point) begin
			if (n < 3) begin
				r = '0;
				r.too_few_points = 1'b1;
				add_expected(r);
			end else begin
				push_segment(recent_pts[0], recent_pts[1], recent_pts[2], opening_pts[0]);
				push_segment(recent_pts[1], recent_pts[2], opening_pts[0], opening_pts[1]);
				push_segment(recent_pts[2], opening_pts[0], opening_pts[1], opening_pts[2]);
			end
			recent_pts = '{default: '0};
			opening_pts = '{default: '0};
			pts_seen = 0;
		end
		if (req.final_point || n >= 3) curve_queue[$].run_end = 1'b1;
	endtask

	task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit fin);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{point_x: x, point_y: y, point_z: z, final_point: fin};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_curve(in_data);
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
	endtask

	task automatic drain_and_set_steps(logic [STEP_W-1:0] s);
		stop_sending();
		while (curve_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
		steps_reg = s;
	endtask

	task automatic send_random_point(bit fin);
		logic [15:0] x, y, z;
		x = 16'($urandom);
		y = 16'($urandom);
		z = 16'($urandom);
		if ($urandom_range(9) == 0) x = $urandom_range(1) ? 16'h7fff : 16'h8000;
		if ($urandom_range(9) == 0) y = $urandom_range(1) ? 16'h7fff : 16'h8000;
		send_point(x, y, z, fin);
	endtask

	task automatic test_directed();
		send_point(16'h0000, 16'h0000, 16'h0000, 1'b1);
		send_point(16'h7fff, 16'h8000, 16'h0100, 1'b0);
		send_point(16'h8000, 16'h7fff, 16'hff00, 1'b1);
		send_point(16'h1234, 16'h4321, 16'h0f0f, 1'b0);
		send_point(16'h0001, 16'hffff, 16'h5555, 1'b0);
		send_point(16'haaaa, 16'h0000, 16'h8000, 1'b1);
		for (int k = 0; k < 4; k++) send_point(16'h7fff, 16'h7fff, 16'h7fff, k == 3);
		for (int k = 0; k < 5; k++) send_point(16'h8000, 16'h8000, 16'h8000, k == 4);
		for (int k = 0; k < 6; k++)
			send_point(k[0] ? 16'h7fff : 16'h8000, k[0] ? 16'h8000 : 16'h7fff,
				16'h0080, k == 5);
	endtask

	task automatic test_step_extremes();
		logic [STEP_W-1:0] sets[5] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17};
		foreach (sets[m]) begin
			drain_and_set_steps(sets[m]);
			for (int k = 0; k < 5; k++) send_random_point(k == 4);
		end
		drain_and_set_steps(RESET_STEPS);
	endtask

	task automatic random_curves(int count);
		int sent, len;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 9);
			for (int k = 0; k < len; k++) send_random_point(k == len - 1);
			sent += len;
		end
	endtask

	task automatic test_random();
		drain_and_set_steps(STEP_W'($urandom_range(1, 6)));
		send_idle_pct = 31;
		recv_idle_pct = 67;
		random_curves(135);
		drain_and_set_steps(STEP_W'($urandom_range(0, 31)));
		send_idle_pct = 67;
		recv_idle_pct = 31;
		random_curves(135);
		drain_and_set_steps(STEP_W'($urandom_range(1, 4)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_curves(135);
	endtask

	task automatic test_backpressure();
		drain_and_set_steps(5'd3);
		recv_hold = 1'b1;
		random_curves(20);
		stop_sending();
		wait (!recv_hold);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_step_extremes();
		test_backpressure();
		test_random();
		stop_sending();
		while (curve_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) $display("tb_closed_cubic_bspline_tessellator OK");
		else $display("tb_closed_cubic_bspline_tessellator NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (recv_hold) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		wait (recv_hold);
		repeat (400) @(posedge clk);
		recv_hold = 1'b0;
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (curve_queue.size() == 0) begin
				$error("unexpected result %h", out_data);
				errors++;
			end else begin
				want = curve_queue.pop_front();
				if (out_data.curve_x !== want.curve_x) begin
					$error("curve_x expected %0d actual %0d", want.curve_x, out_data.curve_x);
					errors++;
				end
				if (out_data.curve_y !== want.curve_y) begin
					$error("curve_y expected %0d actual %0d", want.curve_y, out_data.curve_y);
					errors++;
				end
				if (out_data.curve_z !== want.curve_z) begin
					$error("curve_z expected %0d actual %0d", want.curve_z, out_data.curve_z);
					errors++;
				end
				if (out_data.run_end !== want.run_end) begin
					$error("run_end expected %0b actual %0b", want.run_end, out_data.run_end);
					errors++;
				end
				if (out_data.too_few_points !== want.too_few_points) begin
					$error("too_few_points expected %0b actual %0b",
						want.too_few_points, out_data.too_few_points);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || recv_hold)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_closed_cubic_bspline_tessellator NOT OK");
			$finish;
		end
	end
endmodule

[closed_cubic_bspline_tessellator.f]
design/ccbt_pkg.sv
design/ccbt_front.sv
design/ccbt_queue.sv
design/ccbt_eval.sv
design/closed_cubic_bspline_tessellator.sv
bench/tb_closed_cubic_bspline_tessellator.sv
